FILE: sv/cwpf_pkg.sv
package cwpf_pkg;

  localparam int MAX_HALF_TAPS = 255;
  localparam int NUM_TAPS      = 2 * MAX_HALF_TAPS + 1;
  localparam int TAP_AW        = $clog2(NUM_TAPS);
  localparam int SAMPLE_WIDTH  = 16;
  localparam int TAP_WIDTH     = 18;
  localparam int HALF_W        = 8;
  localparam int SHIFT_W       = 6;
  localparam int COUNT_W       = 21;
  localparam int POWER_W       = 48;
  localparam int TIME_W        = 20;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;
  localparam int CMD_W         = 2;
  localparam int IN_DATA_W     = 64;
  localparam int IN_USER_W     = 3;
  localparam int OUT_DATA_W    = 72;
  localparam int PROD_W        = SAMPLE_WIDTH + TAP_WIDTH;
  localparam int ACC_W         = PROD_W + TAP_AW;
  localparam int SPLIT_LO      = (ACC_W + 1) / 2;
  localparam int SPLIT_HI      = ACC_W - SPLIT_LO;
  localparam int SQ_W          = 2 * SPLIT_LO;
  localparam int SUM_W         = 2 * ACC_W + 1;
  localparam int SQ_SH_W       = $clog2(SUM_W);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;
  localparam int SQ_STEPS      = 6;
  localparam int STEP_W        = 3;

  localparam logic [COUNT_W-1:0]   COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_SHIFT = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_PAD    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_SAMPLE,
    KIND_PAD
  } kind_t;

  typedef struct packed {
    kind_t                          kind;
    logic [TAP_AW-1:0]              tap_index;
    logic signed [TAP_WIDTH-1:0]    tap_real;
    logic signed [TAP_WIDTH-1:0]    tap_imag;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           record_start;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SQUARE,
    ST_SUM,
    ST_EMIT
  } state_t;

endpackage

FILE: sv/cwpf_front.sv
module cwpf_front
  import cwpf_pkg::*;
(
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  push_valid,
  input  logic                  push_ready,
  output item_t                 push_item
);

  cmd_t cmd;
  logic keep;

  always_comb begin
    cmd = cmd_t'(s_tuser[CMD_W-1:0]);
    push_item.tap_index    = s_tdata[TAP_AW-1:0];
    push_item.tap_real     = s_tdata[TAP_AW +: TAP_WIDTH];
    push_item.tap_imag     = s_tdata[TAP_AW+TAP_WIDTH +: TAP_WIDTH];
    push_item.sample       = s_tdata[TAP_AW+2*TAP_WIDTH +: SAMPLE_WIDTH];
    push_item.record_start = s_tuser[CMD_W];
    push_item.kind         = KIND_LOAD;
    keep                   = 1'b0;
    unique case (cmd)
      CMD_LOAD: begin
        push_item.kind = KIND_LOAD;
        keep = ({1'b0, push_item.tap_index} < (TAP_AW+1)'(NUM_TAPS));
      end
      CMD_SAMPLE: begin
        push_item.kind = KIND_SAMPLE;
        keep = 1'b1;
      end
      CMD_PAD: begin
        push_item.kind = KIND_PAD;
        keep = 1'b1;
      end
      CMD_NOP: begin
        keep = 1'b0;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid & keep;

endmodule

FILE: sv/cwpf_queue.sv
module cwpf_queue
  import cwpf_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!do_push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: sv/cwpf_back.sv
module cwpf_back
  import cwpf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  item_t                  pop_item,
  input  logic [HALF_W-1:0]      half_length,
  input  logic [SHIFT_W-1:0]     power_shift,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_DATA_W-1:0]  m_tdata
);

  state_t state;
  state_t state_next;

  logic signed [TAP_WIDTH-1:0]    tap_re_mem [NUM_TAPS];
  logic signed [TAP_WIDTH-1:0]    tap_im_mem [NUM_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] ring_mem [2**TAP_AW];

  logic [TAP_AW-1:0]  wp;
  logic [COUNT_W-1:0] count;
  logic [TAP_AW-1:0]  cur_wp;
  logic [COUNT_W-1:0] cur_m;
  logic [HALF_W-1:0]  cur_h;
  logic [TAP_AW-1:0]  k;

  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [TAP_WIDTH-1:0]    tr_q;
  logic signed [TAP_WIDTH-1:0]    ti_q;
  logic                           live_q;
  logic                           v1;
  logic signed [PROD_W-1:0]       pr;
  logic signed [PROD_W-1:0]       pi;
  logic                           v2;
  logic signed [ACC_W-1:0]        acc_re;
  logic signed [ACC_W-1:0]        acc_im;

  logic [ACC_W-1:0]   mag_re;
  logic [ACC_W-1:0]   mag_im;
  logic [STEP_W-1:0]  sq_step;
  logic [SPLIT_LO-1:0] op_a;
  logic [SPLIT_LO-1:0] op_b;
  logic [SQ_SH_W-1:0]  op_sh;
  logic [SQ_W-1:0]     sq_prod;
  logic [SQ_SH_W-1:0]  sq_sh;
  logic                pv;
  logic [SUM_W-1:0]    psum;
  logic [SUM_W-1:0]    shifted;

  logic [HALF_W-1:0]  h_now;
  logic [COUNT_W-1:0] m_now;
  logic               is_sample;
  logic               take;
  logic               mac_issue;
  logic               last_k;
  logic               drained;
  logic               sq_issue;
  logic               emit;
  logic [TAP_AW-1:0]  rd_addr;

  always_comb begin
    h_now = (half_length > HALF_W'(MAX_HALF_TAPS)) ? HALF_W'(MAX_HALF_TAPS) : half_length;
    m_now = pop_item.record_start ? '0 : count;
    is_sample = (pop_item.kind == KIND_SAMPLE) || (pop_item.kind == KIND_PAD);
    last_k = (k == {cur_h, 1'b0});
    drained = !v1 && !v2;
    rd_addr = cur_wp - k;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop_valid && is_sample && (m_now >= COUNT_W'(h_now))) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (last_k) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sq_step == STEP_W'(SQ_STEPS - 1)) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (!pv) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_ready = (state == ST_IDLE);
    take      = pop_ready && pop_valid;
    mac_issue = (state == ST_MAC);
    sq_issue  = (state == ST_SQUARE);
    emit      = (state == ST_EMIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (pop_item.kind == KIND_LOAD)) begin
      tap_re_mem[pop_item.tap_index] <= pop_item.tap_real;
      tap_im_mem[pop_item.tap_index] <= pop_item.tap_imag;
    end
    tr_q <= tap_re_mem[k];
    ti_q <= tap_im_mem[k];
  end

  always_ff @(posedge clk) begin
    if (take && is_sample) begin
      ring_mem[wp] <= (pop_item.kind == KIND_SAMPLE) ? pop_item.sample : '0;
    end
    x_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      count <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      pv    <= 1'b0;
    end else begin
      v1 <= mac_issue;
      v2 <= v1;
      pv <= sq_issue;
      if (take && is_sample) begin
        wp    <= wp + 1'b1;
        count <= (m_now == COUNT_MAX) ? COUNT_MAX : m_now + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_wp <= wp;
      cur_m  <= m_now;
      cur_h  <= h_now;
      k      <= '0;
      acc_re <= '0;
      acc_im <= '0;
    end
    if (mac_issue) begin
      k <= k + 1'b1;
    end
    live_q <= (COUNT_W'(k) <= cur_m);
    pr <= (live_q ? PROD_W'(x_q) : '0) * PROD_W'(tr_q);
    pi <= (live_q ? PROD_W'(x_q) : '0) * PROD_W'(ti_q);
    if (v2) begin
      acc_re <= acc_re + ACC_W'(pr);
      acc_im <= acc_im + ACC_W'(pi);
    end
  end

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    op_sh = '0;
    unique case (sq_step)
      3'd0: begin
        op_a = mag_re[SPLIT_LO-1:0];
        op_b = mag_re[SPLIT_LO-1:0];
      end
      3'd1: begin
        op_a  = SPLIT_LO'(mag_re[ACC_W-1:SPLIT_LO]);
        op_b  = SPLIT_LO'(mag_re[ACC_W-1:SPLIT_LO]);
        op_sh = SQ_SH_W'(2 * SPLIT_LO);
      end
      3'd2: begin
        op_a  = SPLIT_LO'(mag_re[ACC_W-1:SPLIT_LO]);
        op_b  = mag_re[SPLIT_LO-1:0];
        op_sh = SQ_SH_W'(SPLIT_LO + 1);
      end
      3'd3: begin
        op_a = mag_im[SPLIT_LO-1:0];
        op_b = mag_im[SPLIT_LO-1:0];
      end
      3'd4: begin
        op_a  = SPLIT_LO'(mag_im[ACC_W-1:SPLIT_LO]);
        op_b  = SPLIT_LO'(mag_im[ACC_W-1:SPLIT_LO]);
        op_sh = SQ_SH_W'(2 * SPLIT_LO);
      end
      3'd5: begin
        op_a  = SPLIT_LO'(mag_im[ACC_W-1:SPLIT_LO]);
        op_b  = mag_im[SPLIT_LO-1:0];
        op_sh = SQ_SH_W'(SPLIT_LO + 1);
      end
      default: begin
        op_sh = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_DRAIN) begin
      mag_re  <= acc_re[ACC_W-1] ? ACC_W'(-acc_re) : ACC_W'(acc_re);
      mag_im  <= acc_im[ACC_W-1] ? ACC_W'(-acc_im) : ACC_W'(acc_im);
      sq_step <= '0;
      psum    <= '0;
    end
    if (sq_issue) begin
      sq_step <= sq_step + 1'b1;
    end
    sq_prod <= SQ_W'(op_a) * SQ_W'(op_b);
    sq_sh   <= op_sh;
    if (pv) begin
      psum <= psum + (SUM_W'(sq_prod) << sq_sh);
    end
  end

  assign shifted = psum >> power_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata[POWER_W-1:0] <= (shifted[SUM_W-1:POWER_W] != '0) ?
                              {POWER_W{1'b1}} : shifted[POWER_W-1:0];
      m_tdata[POWER_W +: TIME_W] <= TIME_W'(cur_m - COUNT_W'(cur_h));
      m_tdata[OUT_DATA_W-1:POWER_W+TIME_W] <= '0;
    end
  end

endmodule

FILE: sv/complex_wavelet_power_filter_core.sv
// Streams real Q15 samples through a complex FIR of 2*H+1 wavelet taps (H is the
// half_length register) and delivers the shifted, saturated squared magnitude.
// Load items write taps; sample and pad items each yield one power value once H
// items of the record have entered. A load item leaves the back end idle; a sample
// or pad item that yields a power keeps it busy while the single complex
// multiply-accumulate unit walks the taps one per cycle, then while the squaring
// runs on one shared multiplier. A two-entry queue lets new items be taken
// while the back end works and while a result waits on the output.
module complex_wavelet_power_filter_core
  import cwpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tap_index, tap_real, tap_imag, sample
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // cmd, record_start
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // power, time_index
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [HALF_W-1:0]  half_length;
  logic [SHIFT_W-1:0] power_shift;
  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= '0;
      power_shift <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_LENGTH: half_length <= cfg_data[HALF_W-1:0];
        REG_POWER_SHIFT: power_shift <= cfg_data[SHIFT_W-1:0];
        default: begin
          half_length <= half_length;
        end
      endcase
    end
  end

  cwpf_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  cwpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  cwpf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .half_length (half_length),
    .power_shift (power_shift),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

FILE: verif/complex_wavelet_power_filter_core_tb.sv
module complex_wavelet_power_filter_core_tb;
  import cwpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [POWER_W-1:0] power;
    logic [TIME_W-1:0]  tidx;
  } power_rec_t;

  class power_scoreboard;
    int tap_re [NUM_TAPS];
    int tap_im [NUM_TAPS];
    int delay_line [NUM_TAPS];
    int unsigned record_count;
    int unsigned half_len;
    int unsigned pwr_shift;
    power_rec_t expected_powers[$];
    int errors;

    function new();
      foreach (delay_line[k]) begin
        delay_line[k] = 0;
        tap_re[k] = 0;
        tap_im[k] = 0;
      end
      record_count = 0;
      half_len = 0;
      pwr_shift = 0;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void note_item(cmd_t c, logic [TAP_AW-1:0] idx, logic signed [TAP_WIDTH-1:0] tr,
                            logic signed [TAP_WIDTH-1:0] ti,
                            logic signed [SAMPLE_WIDTH-1:0] smp, bit rs);
      longint re, im;
      logic [127:0] ar, ai, sq;
      int unsigned m, h;
      power_rec_t rec;
      if (c == CMD_LOAD) begin
        if (idx < NUM_TAPS) begin
          tap_re[idx] = tr;
          tap_im[idx] = ti;
        end
        return;
      end
      if (c == CMD_NOP) return;
      if (rs) begin
        foreach (delay_line[k]) delay_line[k] = 0;
        record_count = 0;
      end
      for (int k = NUM_TAPS - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
      delay_line[0] = (c == CMD_SAMPLE) ? int'(smp) : 0;
      m = record_count;
      if (record_count < COUNT_MAX) record_count++;
      h = (half_len > MAX_HALF_TAPS) ? MAX_HALF_TAPS : half_len;
      if (m < h) return;
      re = 0;
      im = 0;
      for (int k = 0; k < 2 * h + 1; k++) begin
        re += longint'(delay_line[k]) * longint'(tap_re[k]);
        im += longint'(delay_line[k]) * longint'(tap_im[k]);
      end
      ar = (re < 0) ? 128'(-re) : 128'(re);
      ai = (im < 0) ? 128'(-im) : 128'(im);
      sq = (ar * ar + ai * ai) >> pwr_shift;
      rec.power = (sq > 128'({POWER_W{1'b1}})) ? {POWER_W{1'b1}} : sq[POWER_W-1:0];
      rec.tidx = TIME_W'(m - h);
      expected_powers = {expected_powers, rec};
    endfunction

    function void check_result(logic [POWER_W-1:0] power, logic [TIME_W-1:0] tidx);
      power_rec_t rec;
      if (expected_powers.size() == 0) begin
        report($sformatf("unexpected result power=%0h time=%0d", power, tidx));
        return;
      end
      rec = expected_powers.pop_front();
      if (power !== rec.power)
        report($sformatf("power %0h, expected %0h", power, rec.power));
      if (tidx !== rec.tidx)
        report($sformatf("time index %0d, expected %0d", tidx, rec.tidx));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  power_scoreboard sb = new();
  bit stalls_on = 1'b1;

  always #4 clk = ~clk;

  complex_wavelet_power_filter_core i_dut (.*);

  always @(negedge clk) begin
    if (!rst) m_tready <= !(stalls_on && $urandom_range(99) < 17);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[47:0], m_tdata[67:48]);
  end

  // Called and returning at a falling edge.
  task automatic send_item(cmd_t c, logic [TAP_AW-1:0] idx, logic signed [TAP_WIDTH-1:0] tr,
                           logic signed [TAP_WIDTH-1:0] ti,
                           logic signed [SAMPLE_WIDTH-1:0] smp, bit rs);
    if (stalls_on && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {3'b0, smp, ti, tr, idx};
    s_tuser <= {rs, c};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_item(c, idx, tr, ti, smp, rs);
    @(negedge clk);
  endtask

  task automatic go_quiet();
    s_tvalid <= 1'b0;
    while (sb.expected_powers.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    if (idx == REG_HALF_LENGTH) sb.half_len = value & 8'hFF;
    else sb.pwr_shift = value & 6'h3F;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_tap(logic [TAP_AW-1:0] idx);
    send_item(CMD_LOAD, idx, TAP_WIDTH'($urandom), TAP_WIDTH'($urandom), '0, $urandom_range(1));
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic run_phase(int unsigned h, int unsigned sh, int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    go_quiet();
    write_reg(REG_HALF_LENGTH, h);
    write_reg(REG_POWER_SHIFT, sh);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        len = $urandom_range(1, 12);
        send_item(CMD_SAMPLE, TAP_AW'($urandom), TAP_WIDTH'($urandom), TAP_WIDTH'($urandom),
                  rand_sample(), 1'b1);
        for (int i = 0; i < len; i++)
          send_item(CMD_SAMPLE, TAP_AW'($urandom), '0, '0, rand_sample(), 1'b0);
        for (int i = 0; i < h && i < 20; i++)
          send_item(CMD_PAD, '0, '0, '0, SAMPLE_WIDTH'($urandom), 1'b0);
        sent += len + 1 + ((h < 20) ? h : 20);
      end else begin
        case ($urandom_range(3))
          0: load_tap(TAP_AW'($urandom_range(NUM_TAPS)));
          1: send_item(CMD_NOP, TAP_AW'($urandom), TAP_WIDTH'($urandom), TAP_WIDTH'($urandom),
                       SAMPLE_WIDTH'($urandom), $urandom_range(1));
          2: send_item(CMD_PAD, '0, '0, '0, SAMPLE_WIDTH'($urandom), $urandom_range(1));
          default: send_item(CMD_SAMPLE, '0, '0, '0, rand_sample(), $urandom_range(1));
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    #50ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NUM_TAPS; i++) load_tap(TAP_AW'(i));
    send_item(CMD_LOAD, 9'd0, 18'sh20000, 18'sh20000, '0, 1'b0);
    send_item(CMD_LOAD, 9'd1, 18'sh1FFFF, 18'sh1FFFF, '0, 1'b1);
    send_item(CMD_LOAD, 9'd2, 18'sh20000, 18'sh1FFFF, '0, 1'b0);
    send_item(CMD_LOAD, 9'd511, 18'sh00123, 18'sh3FFFF, '0, 1'b0);
    send_item(CMD_NOP, 9'h1FF, 18'sh3FFFF, 18'sh3FFFF, 16'hFFFF, 1'b1);
    send_item(CMD_SAMPLE, '0, '0, '0, 16'sh8000, 1'b1);
    send_item(CMD_SAMPLE, '0, '0, '0, 16'sh7FFF, 1'b0);
    send_item(CMD_SAMPLE, '0, '0, '0, 16'sh0000, 1'b0);
    send_item(CMD_PAD, '0, '0, '0, 16'sh7FFF, 1'b0);
    send_item(CMD_PAD, '0, '0, '0, '0, 1'b1);

    go_quiet();
    write_reg(REG_HALF_LENGTH, 1);
    send_item(CMD_SAMPLE, '0, '0, '0, 16'sh8000, 1'b1);
    send_item(CMD_SAMPLE, '0, '0, '0, 16'sh8000, 1'b0);
    go_quiet();
    write_reg(REG_HALF_LENGTH, 2);
    send_item(CMD_SAMPLE, '0, '0, '0, 16'sh7FFF, 1'b0);
    send_item(CMD_PAD, '0, '0, '0, '0, 1'b0);
    send_item(CMD_PAD, '0, '0, '0, '0, 1'b0);

    run_phase(0, 0, 100);
    run_phase(1, 63, 100);
    run_phase(255, 0, 30);
    stalls_on = 1'b0;
    run_phase(3, 20, 120);
    run_phase(2, 45, 100);
    stalls_on = 1'b1;
    run_phase(254, 63, 25);
    for (int p = 0; p < 2; p++)
      run_phase($urandom_range(8), $urandom_range(63), 100);

    go_quiet();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
